FILE: rtl/dprp_pkg.sv
// shared types and constants of the delta patch record parser
`default_nettype none

package dprp_pkg;

    // default width of the kept insert and copy offsets
    localparam int OFFSET_BITS_DEFAULT = 64;

    // header layout, in byte positions
    localparam logic [6:0] HASH_FIRST = 7'd4;
    localparam logic [6:0] HASH_LAST  = 7'd35;
    localparam logic [6:0] TLEN_FIRST = 7'd68;
    localparam logic [6:0] HDR_LAST   = 7'd75;

    // last byte index of an 8-byte little-endian field
    localparam logic [2:0] FIELD_LAST = 3'd7;

    // record mode bytes
    localparam logic [7:0] MODE_INSERT = 8'h00;
    localparam logic [7:0] MODE_COPY   = 8'h01;

    // depth of the queue between parser and output stage
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_MODE,
        PH_INS_OFF,
        PH_INS_LEN,
        PH_INS_DATA,
        PH_CPY_DST,
        PH_CPY_SRC,
        PH_CPY_LEN
    } dprp_phase_t;

    typedef enum logic [1:0] {
        KIND_TLEN  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_COPY  = 2'd2,
        KIND_HASH  = 2'd3
    } dprp_kind_t;

    typedef struct packed {
        dprp_kind_t  kind;
        logic [63:0] address;
        logic [63:0] source_address;
        logic [63:0] count;
        logic [7:0]  data_byte;
    } dprp_result_t;

endpackage

`default_nettype wire

FILE: rtl/dprp_if.sv
// patch byte and result word channel interfaces
`default_nettype none

interface dprp_patch_if;
    logic       valid;
    logic       ready;
    logic [7:0] diff_byte;
    logic       stream_start;

    modport source (output valid, output diff_byte, output stream_start, input ready);
    modport sink   (input valid, input diff_byte, input stream_start, output ready);
endinterface

interface dprp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] address;
    logic [63:0] source_address;
    logic [63:0] count;
    logic [7:0]  data_byte;

    modport source (output valid, output kind, output address, output source_address,
                    output count, output data_byte, input ready);
    modport sink   (input valid, input kind, input address, input source_address,
                    input count, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/dprp_parser.sv
// front end: byte-serial header and record parser
`default_nettype none

module dprp_parser #(
    parameter int OFFSET_BITS = dprp_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire                   clk,
    input  wire                   rst_n,
    dprp_patch_if.sink            patch,
    output logic                  push_valid,
    input  wire                   push_ready,
    output dprp_pkg::dprp_result_t push_data
);

    dprp_pkg::dprp_phase_t phase_reg, phase_next;
    logic [6:0]             cnt_reg, cnt_next;
    logic [63:0]            shift_reg, shift_next;
    logic [OFFSET_BITS-1:0] dest_reg, dest_next;
    logic [OFFSET_BITS-1:0] src_reg, src_next;
    logic [63:0]            remaining_reg, remaining_next;

    dprp_pkg::dprp_phase_t ph;
    logic [6:0]  cnt;
    logic [6:0]  tlen_idx;
    logic [2:0]  k;
    logic [63:0] assembled;
    logic        accept;
    logic        emit;

    assign patch.ready = push_ready;
    assign accept      = patch.valid && push_ready;
    assign push_valid  = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dprp_pkg::PH_HEADER;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            shift_reg     <= shift_next;
            dest_reg      <= dest_next;
            src_reg       <= src_next;
            remaining_reg <= remaining_next;
        end
    end

    always_comb
    begin
        // a start byte sees the parser as just out of reset
        ph       = patch.stream_start ? dprp_pkg::PH_HEADER : phase_reg;
        cnt      = patch.stream_start ? 7'd0 : cnt_reg;
        tlen_idx = 7'(cnt - dprp_pkg::TLEN_FIRST);
        k        = (ph == dprp_pkg::PH_HEADER) ? tlen_idx[2:0] : cnt[2:0];

        // little-endian lane insert, first byte clears the field
        for (int j = 0; j < 8; j++)
        begin
            if (3'(j) == k)
                assembled[8*j +: 8] = patch.diff_byte;
            else if (k == 3'd0)
                assembled[8*j +: 8] = 8'd0;
            else
                assembled[8*j +: 8] = shift_reg[8*j +: 8];
        end

        phase_next     = ph;
        cnt_next       = cnt;
        shift_next     = shift_reg;
        dest_next      = dest_reg;
        src_next       = src_reg;
        remaining_next = remaining_reg;
        emit           = 1'b0;
        push_data      = '{kind: dprp_pkg::KIND_TLEN, address: '0, source_address: '0,
                           count: '0, data_byte: '0};

        case (ph)
            dprp_pkg::PH_HEADER:
            begin
                cnt_next = 7'(cnt + 7'd1);
                if (cnt inside {[dprp_pkg::HASH_FIRST:dprp_pkg::HASH_LAST]})
                begin
                    emit                = 1'b1;
                    push_data.kind      = dprp_pkg::KIND_HASH;
                    push_data.address   = 64'(7'(cnt - dprp_pkg::HASH_FIRST));
                    push_data.data_byte = patch.diff_byte;
                end
                if (cnt >= dprp_pkg::TLEN_FIRST)
                begin
                    shift_next = assembled;
                    if (cnt == dprp_pkg::HDR_LAST)
                    begin
                        phase_next      = dprp_pkg::PH_MODE;
                        cnt_next        = '0;
                        emit            = 1'b1;
                        push_data.kind  = dprp_pkg::KIND_TLEN;
                        push_data.count = assembled;
                    end
                end
            end
            dprp_pkg::PH_MODE:
            begin
                cnt_next = '0;
                if (patch.diff_byte == dprp_pkg::MODE_INSERT)
                    phase_next = dprp_pkg::PH_INS_OFF;
                else if (patch.diff_byte == dprp_pkg::MODE_COPY)
                    phase_next = dprp_pkg::PH_CPY_DST;
            end
            dprp_pkg::PH_INS_OFF, dprp_pkg::PH_INS_LEN,
            dprp_pkg::PH_CPY_DST, dprp_pkg::PH_CPY_SRC, dprp_pkg::PH_CPY_LEN:
            begin
                shift_next = assembled;
                cnt_next   = (k == dprp_pkg::FIELD_LAST) ? 7'd0 : 7'({4'd0, k} + 7'd1);
                if (k == dprp_pkg::FIELD_LAST)
                begin
                    case (ph)
                        dprp_pkg::PH_INS_OFF:
                        begin
                            dest_next  = assembled[OFFSET_BITS-1:0];
                            phase_next = dprp_pkg::PH_INS_LEN;
                        end
                        dprp_pkg::PH_INS_LEN:
                        begin
                            remaining_next = assembled;
                            phase_next     = (assembled == 64'd0) ? dprp_pkg::PH_MODE
                                                                  : dprp_pkg::PH_INS_DATA;
                        end
                        dprp_pkg::PH_CPY_DST:
                        begin
                            dest_next  = assembled[OFFSET_BITS-1:0];
                            phase_next = dprp_pkg::PH_CPY_SRC;
                        end
                        dprp_pkg::PH_CPY_SRC:
                        begin
                            src_next   = assembled[OFFSET_BITS-1:0];
                            phase_next = dprp_pkg::PH_CPY_LEN;
                        end
                        default:
                        begin
                            phase_next               = dprp_pkg::PH_MODE;
                            emit                     = 1'b1;
                            push_data.kind           = dprp_pkg::KIND_COPY;
                            push_data.address        = 64'(dest_reg);
                            push_data.source_address = 64'(src_reg);
                            push_data.count          = assembled;
                        end
                    endcase
                end
            end
            dprp_pkg::PH_INS_DATA:
            begin
                emit                = 1'b1;
                push_data.kind      = dprp_pkg::KIND_WRITE;
                push_data.address   = 64'(dest_reg);
                push_data.data_byte = patch.diff_byte;
                dest_next           = OFFSET_BITS'(dest_reg + 1'b1);
                remaining_next      = 64'(remaining_reg - 64'd1);
                if (remaining_reg == 64'd1)
                    phase_next = dprp_pkg::PH_MODE;
            end
            default:
            begin
                phase_next = dprp_pkg::PH_MODE;
                cnt_next   = '0;
            end
        endcase
    end

    a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dprp_pkg::PH_HEADER |-> cnt_reg <= dprp_pkg::HDR_LAST)
        else $error("header byte count past end of header");

    a_field_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != dprp_pkg::PH_HEADER |-> cnt_reg < 7'd8)
        else $error("field byte count out of range");

    a_data_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dprp_pkg::PH_INS_DATA |-> remaining_reg != 64'd0)
        else $error("payload phase with nothing remaining");

endmodule

`default_nettype wire

FILE: rtl/dprp_queue.sv
// short result queue between parser and output stage
`default_nettype none

module dprp_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push_valid,
    output logic                   push_ready,
    input  dprp_pkg::dprp_result_t push_data,
    output logic                   pop_valid,
    input  wire                    pop,
    output dprp_pkg::dprp_result_t pop_data
);

    localparam int DEPTH  = dprp_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    dprp_pkg::dprp_result_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        count_next = CNT_W'(count_reg + CNT_W'(do_push) - CNT_W'(do_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("parser pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

endmodule

`default_nettype wire

FILE: rtl/dprp_out_stage.sv
// back end: registered result word output
`default_nettype none

module dprp_out_stage (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    pop_valid,
    output logic                   pop,
    input  dprp_pkg::dprp_result_t pop_data,
    dprp_result_if.source          result
);

    logic                   valid_reg;
    dprp_pkg::dprp_result_t word_reg;

    // load whenever the output register is empty or being drained
    assign pop = pop_valid && (!valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || result.ready)
            valid_reg <= pop_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            word_reg <= pop_data;
    end

    assign result.valid          = valid_reg;
    assign result.kind           = word_reg.kind;
    assign result.address        = word_reg.address;
    assign result.source_address = word_reg.source_address;
    assign result.count          = word_reg.count;
    assign result.data_byte      = word_reg.data_byte;

endmodule

`default_nettype wire

FILE: rtl/delta_patch_record_parser.sv
// top level of the delta patch record parser
`default_nettype none

// Takes a delta patch stream one byte per word on the patch channel and turns
// it into result words: 32 expected original-hash bytes (kind 3, address is the
// hash byte index), then the target length (kind 0, count) once the 76-byte
// header is complete, then per record either one write word per insert payload
// byte (kind 1, address and data_byte) or one copy command (kind 2, address is
// the destination, source_address the source, count the length). Mode bytes
// other than insert and copy are skipped, 0xFF included; there is no end
// marker. stream_start on a byte restarts parsing with it as header byte zero.
// Offsets wrap modulo 2^OFFSET_BITS. One byte is accepted every cycle while the
// queue has room: the parser does a single field-lane insert, a 64-bit
// decrement and an offset increment per byte. A result is written into the
// two-entry queue and from there into the output register; stalls on the result
// side back up through the queue to the patch channel.

module delta_patch_record_parser #(
    parameter int OFFSET_BITS = dprp_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire           clk,
    input  wire           rst_n,
    dprp_patch_if.sink    patch,
    dprp_result_if.source result
);

    // parser to queue
    logic                   push_valid;
    logic                   push_ready;
    dprp_pkg::dprp_result_t push_data;

    // queue to output register
    logic                   pop_valid;
    logic                   pop;
    dprp_pkg::dprp_result_t pop_data;

    // front: header and record parsing, owns all stream state
    dprp_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .patch      (patch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decouples the byte side from result stalls
    dprp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    // back: holds the result word until the sink takes it
    dprp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

`default_nettype wire

FILE: verif/tb_delta_patch_record_parser.sv
// self-checking testbench of the delta patch record parser
`default_nettype none

module tb_delta_patch_record_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import dprp_pkg::*;

    // offsets are kept at full width in this bench
    localparam int OFF_BITS = OFFSET_BITS_DEFAULT;
    localparam logic [63:0] ADDR_MASK =
        (OFF_BITS >= 64) ? '1 : ((64'd1 << OFF_BITS) - 64'd1);

    // header length in bytes
    localparam int HDR_BYTES = int'(HDR_LAST) + 1;

    // receiver hold-off and its start, watchdog limit, drain time after the last word, random byte count
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 500;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 700;

    // kinds of stimulus row: a header (whole or cut short), a record, a lone
    // mode byte, or a few raw bytes that break the record framing
    typedef enum logic [2:0] {
        ROW_HEADER,
        ROW_PARTIAL,
        ROW_INSERT,
        ROW_COPY,
        ROW_MODE,
        ROW_NOISE
    } row_kind_t;

    // a: target length / offset / copy destination
    // b: insert length / copy source
    // c: copy length
    // fill: hash fill for headers (00 or ff kept as is, else random), mode byte
    // nb: bytes sent for partial headers, insert payloads and noise
    // w_on: the word that the row ends in is typed in as wa, ws, wc
    typedef struct packed {
        row_kind_t   rk;
        logic        start;
        logic [7:0]  fill;
        logic [7:0]  nb;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic        w_on;
        logic [63:0] wa;
        logic [63:0] ws;
        logic [63:0] wc;
    } row_t;

    localparam int PLAN_ROWS = 18;

    localparam row_t PLAN [0:PLAN_ROWS-1] = '{
        // first header straight out of reset, no restart flag, zero hash and length
        '{ROW_HEADER, 1'b0, 8'h00, 8'd0, 64'd0, 64'd0, 64'd0,
          1'b1, 64'd0, 64'd0, 64'd0},
        // zero-length insert, the next byte is a mode byte again
        '{ROW_INSERT, 1'b0, 8'h00, 8'd0, 64'd0, 64'd0, 64'd0,
          1'b0, 64'd0, 64'd0, 64'd0},
        // zero-length copy still gives a copy command
        '{ROW_COPY, 1'b0, 8'h00, 8'd0, 64'd0, 64'd0, 64'd0,
          1'b1, 64'd0, 64'd0, 64'd0},
        // unknown mode bytes, the all-ones byte among them, are skipped
        '{ROW_MODE, 1'b0, 8'hff, 8'd0, 64'd0, 64'd0, 64'd0,
          1'b0, 64'd0, 64'd0, 64'd0},
        '{ROW_MODE, 1'b0, 8'h02, 8'd0, 64'd0, 64'd0, 64'd0,
          1'b0, 64'd0, 64'd0, 64'd0},
        '{ROW_MODE, 1'b0, 8'h80, 8'd0, 64'd0, 64'd0, 64'd0,
          1'b0, 64'd0, 64'd0, 64'd0},
        // insert addresses running over the top wrap to zero
        '{ROW_INSERT, 1'b0, 8'h00, 8'd4, 64'hffff_ffff_ffff_fffe, 64'd4, 64'd0,
          1'b0, 64'd0, 64'd0, 64'd0},
        // all-ones copy fields
        '{ROW_COPY, 1'b0, 8'h00, 8'd0, '1, '1, '1,
          1'b1, '1, '1, '1},
        // destination and source byte lanes all distinct, so a lane swap shows
        '{ROW_COPY, 1'b0, 8'h00, 8'd0, 64'h0123_4567_89ab_cdef,
          64'hfedc_ba98_7654_3210, 64'h8000_0000_0000_0001,
          1'b1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
          64'h8000_0000_0000_0001},
        '{ROW_INSERT, 1'b0, 8'h00, 8'd3, 64'h8000_0000_0000_0000, 64'd3, 64'd0,
          1'b0, 64'd0, 64'd0, 64'd0},
        // header cut short, then restarted in the middle of the header
        '{ROW_PARTIAL, 1'b1, 8'h00, 8'd40, 64'd0, 64'd0, 64'd0,
          1'b0, 64'd0, 64'd0, 64'd0},
        '{ROW_HEADER, 1'b1, 8'hff, 8'd0, '1, 64'd0, 64'd0,
          1'b1, 64'd0, 64'd0, '1},
        // insert payload cut short, restart while payload is still owed
        '{ROW_INSERT, 1'b0, 8'h00, 8'd3, 64'd5, 64'd10, 64'd0,
          1'b0, 64'd0, 64'd0, 64'd0},
        '{ROW_HEADER, 1'b1, 8'h5a, 8'd0, 64'h0102_0304_0506_0708, 64'd0, 64'd0,
          1'b1, 64'd0, 64'd0, 64'h0102_0304_0506_0708},
        '{ROW_INSERT, 1'b0, 8'h00, 8'd1, 64'h1000, 64'd1, 64'd0,
          1'b0, 64'd0, 64'd0, 64'd0},
        '{ROW_COPY, 1'b0, 8'h00, 8'd0, 64'h10, 64'h20, 64'h30,
          1'b1, 64'h10, 64'h20, 64'h30},
        // copy mode byte, then restart on the first destination byte
        '{ROW_MODE, 1'b0, 8'h01, 8'd0, 64'd0, 64'd0, 64'd0,
          1'b0, 64'd0, 64'd0, 64'd0},
        '{ROW_HEADER, 1'b1, 8'h00, 8'd0, 64'h8000_0000_0000_0000, 64'd0, 64'd0,
          1'b1, 64'd0, 64'd0, 64'h8000_0000_0000_0000}
    };

    logic clk;
    logic rst_n;

    dprp_patch_if  patch_ch ();
    dprp_result_if result_ch ();

    delta_patch_record_parser #(
        .OFFSET_BITS (OFF_BITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .patch  (patch_ch),
        .result (result_ch)
    );

    // parser state of the bench's own copy
    dprp_phase_t ps_phase;
    logic [6:0]  ps_idx;
    logic [63:0] ps_field;
    logic [63:0] ps_dest;
    logic [63:0] ps_src;
    logic [63:0] ps_left;

    // result words still owed by the block, oldest first
    dprp_result_t due_words [$];

    // a typed-in word replaces the computed one of the same kind
    logic         want_armed;
    dprp_result_t want_word;

    int fault_count;
    int bytes_in;
    int burst_left;
    bit long_done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_fault(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        fault_count++;
        $display("ERROR at %0t: %s got %h, want %h", $time, what, got, want);
    endtask

    task automatic clear_parser();
        ps_phase = PH_HEADER;
        ps_idx   = '0;
        ps_field = '0;
        ps_dest  = '0;
        ps_src   = '0;
        ps_left  = '0;
    endtask

    // one byte into the little-endian field; high on its last byte
    function automatic logic take_lane(input logic [7:0] b);
        logic [2:0] k;
        k = ps_idx[2:0];
        if (k == 3'd0)
            ps_field = 64'(b);
        else
            ps_field[8*k +: 8] = b;
        if (k == FIELD_LAST)
        begin
            ps_idx = '0;
            return 1'b1;
        end
        ps_idx = 7'(k) + 7'd1;
        return 1'b0;
    endfunction

    // advance the bench's parser by one accepted byte, queue any word it owes
    task automatic parse_byte(input logic [7:0] b, input logic st);
        dprp_result_t w;
        logic         hit;
        logic [6:0]   k;
        w   = '0;
        hit = 1'b0;
        if (st)
            clear_parser();
        case (ps_phase)
            PH_HEADER:
            begin
                k      = ps_idx;
                ps_idx = ps_idx + 7'd1;
                if (k >= HASH_FIRST && k <= HASH_LAST)
                begin
                    w.kind      = KIND_HASH;
                    w.address   = 64'(k - HASH_FIRST);
                    w.data_byte = b;
                    hit         = 1'b1;
                end
                else if (k >= TLEN_FIRST)
                begin
                    if (k == TLEN_FIRST)
                        ps_field = 64'(b);
                    else
                        ps_field[8*(k - TLEN_FIRST) +: 8] = b;
                    if (k == HDR_LAST)
                    begin
                        ps_phase = PH_MODE;
                        ps_idx   = '0;
                        w.kind   = KIND_TLEN;
                        w.count  = ps_field;
                        hit      = 1'b1;
                    end
                end
            end
            PH_MODE:
            begin
                ps_idx = '0;
                if (b == MODE_INSERT)
                    ps_phase = PH_INS_OFF;
                else if (b == MODE_COPY)
                    ps_phase = PH_CPY_DST;
            end
            PH_INS_OFF:
                if (take_lane(b))
                begin
                    ps_dest  = ps_field & ADDR_MASK;
                    ps_phase = PH_INS_LEN;
                end
            PH_INS_LEN:
                if (take_lane(b))
                begin
                    ps_left  = ps_field;
                    ps_phase = (ps_left == 64'd0) ? PH_MODE : PH_INS_DATA;
                end
            PH_INS_DATA:
            begin
                w.kind      = KIND_WRITE;
                w.address   = ps_dest & ADDR_MASK;
                w.data_byte = b;
                hit         = 1'b1;
                ps_dest     = (w.address + 64'd1) & ADDR_MASK;
                ps_left     = ps_left - 64'd1;
                if (ps_left == 64'd0)
                    ps_phase = PH_MODE;
            end
            PH_CPY_DST:
                if (take_lane(b))
                begin
                    ps_dest  = ps_field & ADDR_MASK;
                    ps_phase = PH_CPY_SRC;
                end
            PH_CPY_SRC:
                if (take_lane(b))
                begin
                    ps_src   = ps_field & ADDR_MASK;
                    ps_phase = PH_CPY_LEN;
                end
            PH_CPY_LEN:
                if (take_lane(b))
                begin
                    ps_phase         = PH_MODE;
                    w.kind           = KIND_COPY;
                    w.address        = ps_dest & ADDR_MASK;
                    w.source_address = ps_src & ADDR_MASK;
                    w.count          = ps_field;
                    hit              = 1'b1;
                end
            default:
            begin
                ps_phase = PH_MODE;
                ps_idx   = '0;
            end
        endcase
        if (hit)
        begin
            if (want_armed && w.kind == want_word.kind)
            begin
                w          = want_word;
                want_armed = 1'b0;
            end
            due_words.push_back(w);
        end
    endtask

    // offer one byte; the sender works in bursts with idle gaps between them
    task automatic put_byte(input logic [7:0] b, input logic st);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            patch_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        patch_ch.valid        <= 1'b1;
        patch_ch.diff_byte    <= b;
        patch_ch.stream_start <= st;
        do
            @(posedge clk);
        while (!patch_ch.ready);
        parse_byte(b, st);
        bytes_in++;
        burst_left--;
    endtask

    task automatic put_field(input logic [63:0] v);
        for (int k = 0; k < 8; k++)
            put_byte(v[8*k +: 8], 1'b0);
    endtask

    task automatic play_row(input row_t r);
        logic [7:0] b;
        int         n;
        if (r.w_on)
        begin
            want_armed               = 1'b1;
            want_word.kind           = (r.rk == ROW_HEADER) ? KIND_TLEN : KIND_COPY;
            want_word.address        = r.wa;
            want_word.source_address = r.ws;
            want_word.count          = r.wc;
            want_word.data_byte      = 8'h00;
        end
        case (r.rk)
            ROW_HEADER, ROW_PARTIAL:
            begin
                n = (r.rk == ROW_HEADER) ? HDR_BYTES : int'(r.nb);
                for (int i = 0; i < n; i++)
                begin
                    if (i >= int'(TLEN_FIRST))
                        b = r.a[8*(i - int'(TLEN_FIRST)) +: 8];
                    else if (i >= int'(HASH_FIRST) && i <= int'(HASH_LAST)
                             && (r.fill == 8'h00 || r.fill == 8'hff))
                        b = r.fill;
                    else
                        b = 8'($urandom);
                    put_byte(b, r.start && i == 0);
                end
            end
            ROW_INSERT:
            begin
                put_byte(MODE_INSERT, 1'b0);
                put_field(r.a);
                put_field(r.b);
                for (int i = 0; i < int'(r.nb); i++)
                    put_byte(8'($urandom), 1'b0);
            end
            ROW_COPY:
            begin
                put_byte(MODE_COPY, 1'b0);
                put_field(r.a);
                put_field(r.b);
                put_field(r.c);
            end
            ROW_MODE:
                put_byte(r.fill, 1'b0);
            default:
                for (int i = 0; i < int'(r.nb); i++)
                    put_byte(8'($urandom), 1'b0);
        endcase
        want_armed = 1'b0;
    endtask

    // offsets favour the edges: zero, all ones, just below the top, one bit, plus random and small values
    function automatic logic [63:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            2: return '1 - 64'($urandom_range(0, 3));
            3: return {$urandom, $urandom};
            4: return 64'd1 << $urandom_range(0, 63);
            default: return 64'($urandom_range(0, 1000));
        endcase
    endfunction

    function automatic row_t random_header();
        row_t r;
        r       = '0;
        r.rk    = ROW_HEADER;
        // mostly a proper restart, sometimes header bytes land mid-record
        r.start = ($urandom_range(0, 4) != 0);
        r.fill  = 8'($urandom);
        r.a     = pick_offset();
        return r;
    endfunction

    function automatic row_t random_row();
        row_t r;
        int   pick;
        int   len;
        r    = '0;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            r = random_header();
        else if (pick < 9)
        begin
            r.rk    = ROW_PARTIAL;
            r.start = 1'b1;
            r.nb    = 8'($urandom_range(1, HDR_BYTES - 1));
        end
        else if (pick < 45)
        begin
            r.rk = ROW_INSERT;
            r.a  = pick_offset();
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 48) : $urandom_range(0, 6);
            r.b  = 64'(len);
            r.nb = 8'(len);
            if (len > 0 && $urandom_range(0, 19) == 0)
                r.nb = 8'($urandom_range(0, len - 1));
        end
        else if (pick < 80)
        begin
            r.rk = ROW_COPY;
            r.a  = pick_offset();
            r.b  = pick_offset();
            r.c  = pick_offset();
        end
        else if (pick < 92)
        begin
            r.rk   = ROW_MODE;
            r.fill = 8'($urandom_range(2, 255));
        end
        else
        begin
            r.rk = ROW_NOISE;
            r.nb = 8'($urandom_range(1, 5));
        end
        return r;
    endfunction

    // stimulus: reset, directed table, then random records
    initial
    begin
        row_t r;
        int   start_count;
        rst_n                 = 1'b0;
        patch_ch.valid        = 1'b0;
        patch_ch.diff_byte    = 8'h00;
        patch_ch.stream_start = 1'b0;
        fault_count           = 0;
        bytes_in              = 0;
        burst_left            = 0;
        want_armed            = 1'b0;
        want_word             = '0;
        clear_parser();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
            play_row(PLAN[i]);

        // well-formed records with random content, plus broken framing that
        // is always followed by a header to pull the parse back into step
        start_count = bytes_in;
        while (bytes_in - start_count < RANDOM_BYTES)
        begin
            r = random_row();
            play_row(r);
            if (r.rk == ROW_PARTIAL || r.rk == ROW_NOISE
                || (r.rk == ROW_INSERT && 64'(r.nb) != r.b))
                play_row(random_header());
        end
        patch_ch.valid <= 1'b0;

        while (due_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("delta_patch_record_parser: match");
        else
            $display("delta_patch_record_parser: mismatch");
        $finish;
    end

    // receiver: stall patterns that change every so often, plus one long
    // hold-off so the two-entry queue fills and the patch side backs up
    initial
    begin
        int         rx_mode;
        int         rx_left;
        logic [1:0] rx_tick;
        result_ch.ready = 1'b0;
        long_done       = 1'b0;
        rx_mode         = 0;
        rx_left         = 0;
        rx_tick         = '0;
        forever
        begin
            @(posedge clk);
            if (!long_done && bytes_in >= HOLD_AFTER)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_done = 1'b1;
            end
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= 1'($urandom_range(0, 1));
                2: result_ch.ready <= (rx_tick != 2'd3);
                default: result_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // each accepted word against the oldest one owed
    initial
    begin
        dprp_result_t w;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (due_words.size() == 0)
                    report_fault("word with nothing owed, kind", 64'(result_ch.kind), 64'd0);
                else
                begin
                    w = due_words.pop_front();
                    if (result_ch.kind != w.kind)
                        report_fault("kind", 64'(result_ch.kind), 64'(w.kind));
                    if (result_ch.address != w.address)
                        report_fault("address", result_ch.address, w.address);
                    if (result_ch.source_address != w.source_address)
                        report_fault("source_address", result_ch.source_address,
                                     w.source_address);
                    if (result_ch.count != w.count)
                        report_fault("count", result_ch.count, w.count);
                    if (result_ch.data_byte != w.data_byte)
                        report_fault("data_byte", 64'(result_ch.data_byte),
                                     64'(w.data_byte));
                end
            end
        end
    end

    // watchdog: too long with no word moving on either side ends the run
    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((patch_ch.valid && patch_ch.ready) || (result_ch.valid && result_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("delta_patch_record_parser: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
